/* src/fdl_pkg.sv */
// ----------------------------------------------------------------------------
// fdl_pkg: shared types and constants
// Opcodes, query constants and the result beat passed from the lookup
// sequencer to the output stage of the flat directory lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [7:0] QUERY_END = 8'h0A;

    localparam int QUERY_CHARS = 10;
    localparam int MAX_RESULTS = 21;
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic       found;
        logic [8:0] entry_offset;
        logic       sector_valid;
        logic [4:0] slot_index;
        logic [7:0] sector_number;
        logic [4:0] quotient;
        logic       last;
    } fdl_beat_t;

endpackage

`default_nettype wire

/* src/fdl_ram.sv */
// ----------------------------------------------------------------------------
// fdl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/fdl_seq.sv */
// ----------------------------------------------------------------------------
// fdl_seq: lookup sequencer
// Walks the directory one byte per cycle through a single compare unit:
// name bytes of each entry first, then the sector slots of the matching one.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_seq #(
    parameter int DIR_BYTES         = 512,
    parameter int ENTRY_BYTES       = 32,
    parameter int NAME_CHARS        = 10,
    parameter int SECTORS_PER_TRACK = 18
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         lookup_start,
    input  wire logic [63:0]                  name_head,
    input  wire logic [15:0]                  name_tail,
    output logic                              busy,
    output logic      [$clog2(DIR_BYTES)-1:0] rd_addr,
    input  wire logic [7:0]                   rd_data,
    output logic                              emit,
    output fdl_pkg::fdl_beat_t                emit_beat
);

    localparam int AW    = $clog2(DIR_BYTES);
    localparam int BW    = $clog2(DIR_BYTES + ENTRY_BYTES) + 1;
    localparam int PW    = $clog2(ENTRY_BYTES + 1);
    localparam int CW    = $clog2(fdl_pkg::MAX_RESULTS + 1);
    localparam int RECIP =
        ((2 ** fdl_pkg::RECIP_SHIFT) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NAME  = 2'd1;
    localparam logic [1:0] ST_SLOT  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [PW-1:0] NAME_LAST  = PW'(NAME_CHARS - 1);
    localparam logic [PW-1:0] NAME_END   = PW'(NAME_CHARS);
    localparam logic [PW-1:0] SLOT_FIRST = PW'(NAME_CHARS + 1);
    localparam logic [PW-1:0] SLOT_LAST  = PW'(ENTRY_BYTES - 1);
    localparam logic [PW-1:0] SLOT_END   = PW'(ENTRY_BYTES);
    localparam logic [BW-1:0] ENTRY_STEP = BW'(ENTRY_BYTES);
    localparam logic [BW-1:0] DIR_END    = BW'(DIR_BYTES);
    localparam logic [CW-1:0] CNT_MAX    = CW'(fdl_pkg::MAX_RESULTS);

    logic [1:0]          state_reg, state_next;
    logic [BW-1:0]       base_reg, base_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [PW-1:0]       chk_pos_reg, chk_pos_next;
    logic                chk_oor_reg, chk_oor_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    fdl_pkg::fdl_beat_t  pend_reg, pend_next;
    logic [7:0]          qry_reg [fdl_pkg::QUERY_CHARS];

    logic [BW-1:0]       rd_sum;
    logic                rd_oor;
    logic [BW-1:0]       next_entry;
    logic [7:0]          ent_byte;
    logic [3:0]          qidx;
    logic [7:0]          q_byte;
    logic                end_hit;
    logic                char_eq;
    logic [31:0]         prod;
    logic [31:0]         base_ext;
    logic [PW-1:0]       slot_diff;
    logic [31:0]         slot_ext;

    assign rd_sum     = base_reg + BW'(pos_reg);
    assign rd_oor     = (rd_sum >= DIR_END);
    assign rd_addr    = rd_sum[AW-1:0];
    assign next_entry = base_reg + ENTRY_STEP;
    assign ent_byte   = chk_oor_reg ? 8'd0 : rd_data;
    assign qidx       = chk_pos_reg[3:0];
    assign q_byte     = (qidx < 4'(fdl_pkg::QUERY_CHARS)) ? qry_reg[qidx] : 8'd0;
    assign end_hit    = (q_byte == fdl_pkg::QUERY_END) && (ent_byte == 8'd0);
    assign char_eq    = (q_byte == ent_byte);
    assign prod       = 32'(ent_byte) * 32'(RECIP);
    assign base_ext   = 32'(base_reg);
    assign slot_diff  = chk_pos_reg - SLOT_FIRST;
    assign slot_ext   = 32'(slot_diff);
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        chk_valid_next  = chk_valid_reg;
        chk_pos_next    = chk_pos_reg;
        chk_oor_next    = chk_oor_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        emit_beat       = pend_reg;
        emit_beat.last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                chk_valid_next = 1'b0;
                if (lookup_start)
                begin
                    state_next      = ST_NAME;
                    base_next       = '0;
                    pos_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_NAME:
            begin
                if (chk_valid_reg && (end_hit || (char_eq && chk_pos_reg == NAME_LAST)))
                begin
                    // hit: keep base, move on to the sector slots
                    state_next             = ST_SLOT;
                    pos_next               = SLOT_FIRST;
                    chk_valid_next         = 1'b0;
                    pend_next              = '0;
                    pend_next.found        = 1'b1;
                    pend_next.entry_offset = base_ext[8:0];
                end
                else if (chk_valid_reg && !char_eq)
                begin
                    // drop the in-flight read; next entry, or flush if last
                    chk_valid_next = 1'b0;
                    pos_next       = '0;
                    if (next_entry >= DIR_END)
                    begin
                        state_next = ST_FLUSH;
                        pend_next  = '0;
                    end
                    else
                    begin
                        base_next = next_entry;
                    end
                end
                else if (pos_reg < NAME_END)
                begin
                    chk_valid_next = 1'b1;
                    chk_pos_next   = pos_reg;
                    chk_oor_next   = rd_oor;
                    pos_next       = pos_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_SLOT:
            begin
                if (chk_valid_reg && ent_byte != 8'd0 && cnt_reg < CNT_MAX)
                begin
                    emit                    = pend_valid_reg;
                    pend_next.sector_valid  = 1'b1;
                    pend_next.slot_index    = slot_ext[4:0];
                    pend_next.sector_number = ent_byte;
                    pend_next.quotient      = prod[fdl_pkg::RECIP_SHIFT +: 5];
                    pend_next.last          = 1'b0;
                    pend_valid_next         = 1'b1;
                    cnt_next                = cnt_reg + 1'b1;
                end
                if (chk_valid_reg && chk_pos_reg == SLOT_LAST)
                begin
                    state_next = ST_FLUSH;
                end
                if (pos_reg < SLOT_END)
                begin
                    chk_valid_next = 1'b1;
                    chk_pos_next   = pos_reg;
                    chk_oor_next   = rd_oor;
                    pos_next       = pos_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_FLUSH:
            begin
                emit           = 1'b1;
                emit_beat.last = 1'b1;
                chk_valid_next = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next     = ST_IDLE;
                chk_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            pos_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            chk_pos_reg    <= '0;
            chk_oor_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            pos_reg        <= pos_next;
            chk_valid_reg  <= chk_valid_next;
            chk_pos_reg    <= chk_pos_next;
            chk_oor_reg    <= chk_oor_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (lookup_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                qry_reg[i] <= name_head[8*i +: 8];
            end
            qry_reg[8] <= name_tail[7:0];
            qry_reg[9] <= name_tail[15:8];
        end
    end

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg != ST_IDLE))
        else $error("result beat emitted while idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_start |=> busy)
        else $error("lookup did not raise busy");

    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !chk_valid_reg)
        else $error("read in flight while idle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("result count overflow");

endmodule

`default_nettype wire

/* src/fdl_chs.sv */
// ----------------------------------------------------------------------------
// fdl_chs: result output stage
// Turns a result beat into cylinder, head and track sector and registers
// every output field together with the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_chs #(
    parameter int SECTORS_PER_TRACK = 18
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               emit,
    input  wire fdl_pkg::fdl_beat_t emit_beat,
    output logic                    strobe,
    output logic                    found,
    output logic [8:0]              entry_offset,
    output logic                    sector_valid,
    output logic [4:0]              slot_index,
    output logic [7:0]              sector_number,
    output logic [2:0]              cylinder,
    output logic                    head_select,
    output logic [4:0]              track_sector,
    output logic                    last
);

    logic        strobe_reg;
    logic        found_reg;
    logic [8:0]  entry_offset_reg;
    logic        sector_valid_reg;
    logic [4:0]  slot_index_reg;
    logic [7:0]  sector_number_reg;
    logic [2:0]  cylinder_reg;
    logic        head_select_reg;
    logic [4:0]  track_sector_reg;
    logic        last_reg;

    logic [15:0] qs;
    logic [7:0]  rem8;

    assign qs   = 16'(emit_beat.quotient) * 16'(SECTORS_PER_TRACK);
    assign rem8 = emit_beat.sector_number - qs[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg         <= emit_beat.found;
            entry_offset_reg  <= emit_beat.entry_offset;
            sector_valid_reg  <= emit_beat.sector_valid;
            slot_index_reg    <= emit_beat.slot_index;
            sector_number_reg <= emit_beat.sector_number;
            last_reg          <= emit_beat.last;
            if (emit_beat.sector_valid)
            begin
                cylinder_reg     <= emit_beat.quotient[3:1];
                head_select_reg  <= emit_beat.quotient[0];
                track_sector_reg <= rem8[4:0] + 5'd1;
            end
            else
            begin
                cylinder_reg     <= 3'd0;
                head_select_reg  <= 1'b0;
                track_sector_reg <= 5'd0;
            end
        end
    end

    assign strobe        = strobe_reg;
    assign found         = found_reg;
    assign entry_offset  = entry_offset_reg;
    assign sector_valid  = sector_valid_reg;
    assign slot_index    = slot_index_reg;
    assign sector_number = sector_number_reg;
    assign cylinder      = cylinder_reg;
    assign head_select   = head_select_reg;
    assign track_sector  = track_sector_reg;
    assign last          = last_reg;

    a_valid_found: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && sector_valid) |-> found)
        else $error("sector beat without a matched entry");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !sector_valid) |-> (last && sector_number == 8'd0 && track_sector == 5'd0))
        else $error("marker beat carries sector data");

endmodule

`default_nettype wire

/* src/flat_directory_lookup_chs_top.sv */
// ----------------------------------------------------------------------------
// flat_directory_lookup_chs_top: flat directory lookup with CHS conversion
// Holds one directory sector and resolves a file name to its floppy sectors.
//
// Command channel: a beat is taken when start is high and busy is low.
// opcode OP_WRITE stores byte_value at byte_address and gives no result;
// busy stays low, so writes may follow back to back. Load the
// whole directory before the first lookup.
// opcode OP_LOOKUP compares the name with each entry, one byte per cycle
// through one compare unit: the name bytes of each entry scanned, then the
// sector slots of the matching entry, then a flush of the final beat and
// the output register. busy stays high for the whole lookup.
// Result channel: each beat shows for one cycle with strobe high; last
// marks the final beat, which appears in the cycle busy falls. A miss or a
// match without sectors gives one beat with sector_valid low.
// The receiver cannot stall; beats are never held.
// Reset clears the sequencer and strobe; directory contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_directory_lookup_chs_top #(
    parameter int DIR_BYTES         = 512,
    parameter int ENTRY_BYTES       = 32,
    parameter int NAME_CHARS        = 10,
    parameter int SECTORS_PER_TRACK = 18
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        opcode,
    input  wire logic [8:0]  byte_address,
    input  wire logic [7:0]  byte_value,
    input  wire logic [63:0] name_head,
    input  wire logic [15:0] name_tail,
    output logic             strobe,
    output logic             found,
    output logic [8:0]       entry_offset,
    output logic             sector_valid,
    output logic [4:0]       slot_index,
    output logic [7:0]       sector_number,
    output logic [2:0]       cylinder,
    output logic             head_select,
    output logic [4:0]       track_sector,
    output logic             last
);

    localparam int AW = $clog2(DIR_BYTES);

    logic               accept;
    logic               lookup_start;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    logic               emit;
    fdl_pkg::fdl_beat_t emit_beat;

    assign accept       = start && !busy;
    assign lookup_start = accept && (opcode == fdl_pkg::OP_LOOKUP);
    assign wr_en        = accept && (opcode == fdl_pkg::OP_WRITE)
                          && (32'(byte_address) < DIR_BYTES);
    assign wr_addr      = AW'(byte_address);

    fdl_ram #(
        .WIDTH (8),
        .DEPTH (DIR_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fdl_seq #(
        .DIR_BYTES         (DIR_BYTES),
        .ENTRY_BYTES       (ENTRY_BYTES),
        .NAME_CHARS        (NAME_CHARS),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_start (lookup_start),
        .name_head    (name_head),
        .name_tail    (name_tail),
        .busy         (busy),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .emit         (emit),
        .emit_beat    (emit_beat)
    );

    fdl_chs #(
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_chs (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (emit),
        .emit_beat     (emit_beat),
        .strobe        (strobe),
        .found         (found),
        .entry_offset  (entry_offset),
        .sector_valid  (sector_valid),
        .slot_index    (slot_index),
        .sector_number (sector_number),
        .cylinder      (cylinder),
        .head_select   (head_select),
        .track_sector  (track_sector),
        .last          (last)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for flat_directory_lookup_chs_top
// Loads a whole directory sector through byte writes, then runs a directed
// table, random writes and name lookups. Each beat is checked field by field,
// CHS numbers too, against a bench directory image or a fixed table beat.
// ----------------------------------------------------------------------------

module tb_top;

    typedef struct packed {
        logic       found;
        logic [8:0] entry_offset;
        logic       sector_valid;
        logic [4:0] slot_index;
        logic [7:0] sector_number;
        logic [2:0] cylinder;
        logic       head_select;
        logic [4:0] track_sector;
        logic       last;
    } chs_beat_t;

    typedef struct {
        logic        op;
        logic [8:0]  addr;
        logic [7:0]  val;
        logic [79:0] qname;
        bit          typed;
        chs_beat_t   beat;
    } stim_row_t;

    localparam int DIR_SIZE   = 512;
    localparam int ENT_STRIDE = 32;
    localparam int NAME_LEN   = 10;
    localparam int SLOT_BASE  = NAME_LEN + 1;
    localparam int TRACK_SECS = 18;

    localparam chs_beat_t MISS_BEAT = '{1'b0, 9'd0, 1'b0, 5'd0, 8'd0, 3'd0, 1'b0, 5'd0, 1'b1};
    localparam chs_beat_t NO_BEAT   = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        opcode = fdl_pkg::OP_WRITE;
    logic [8:0]  byte_address = '0;
    logic [7:0]  byte_value = '0;
    logic [63:0] name_head = '0;
    logic [15:0] name_tail = '0;
    logic        busy;
    logic        strobe;
    logic        found;
    logic [8:0]  entry_offset;
    logic        sector_valid;
    logic [4:0]  slot_index;
    logic [7:0]  sector_number;
    logic [2:0]  cylinder;
    logic        head_select;
    logic [4:0]  track_sector;
    logic        last;

    logic [7:0]  dir_img [0:DIR_SIZE-1];
    logic [7:0]  staged_img [0:DIR_SIZE-1];
    chs_beat_t   chs_expect_q [$];
    stim_row_t   plan [$];

    int idle_pct = 0;
    int errors = 0;
    int commands = 0;
    int lookups = 0;
    int beats_seen = 0;
    int hit_beats = 0;

    flat_directory_lookup_chs_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .name_head    (name_head),
        .name_tail    (name_tail),
        .strobe       (strobe),
        .found        (found),
        .entry_offset (entry_offset),
        .sector_valid (sector_valid),
        .slot_index   (slot_index),
        .sector_number(sector_number),
        .cylinder     (cylinder),
        .head_select  (head_select),
        .track_sector (track_sector),
        .last         (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [79:0] pack_name(input string s);
        logic [79:0] v;
        int i;
        v = '0;
        for (i = 0; i < s.len() && i < NAME_LEN; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic chs_beat_t chs_of(input logic [8:0] off, input int slot,
                                         input int sec);
        chs_beat_t b;
        b.found         = 1'b1;
        b.entry_offset  = off;
        b.sector_valid  = 1'b1;
        b.slot_index    = slot[4:0];
        b.sector_number = sec[7:0];
        b.cylinder      = 3'(sec / (2 * TRACK_SECS));
        b.head_select   = 1'((sec / TRACK_SECS) % 2);
        b.track_sector  = 5'(sec % TRACK_SECS + 1);
        b.last          = 1'b0;
        return b;
    endfunction

    // Scan entries in address order; the first matching name wins.
    function automatic void resolve_name(input logic [79:0] q);
        int base;
        int hit_base;
        int y;
        int x;
        int n;
        bit hit;
        bit same;
        bit done;
        logic [7:0] qc;
        logic [7:0] ec;
        chs_beat_t b;
        hit = 0;
        hit_base = 0;
        n = 0;
        for (base = 0; base < DIR_SIZE && !hit; base += ENT_STRIDE)
        begin
            same = 1;
            done = 0;
            for (y = 0; y < NAME_LEN; y++)
            begin
                qc = q[8*y +: 8];
                ec = dir_img[base + y];
                if (!done)
                begin
                    if (qc == fdl_pkg::QUERY_END && ec == 8'd0)
                        done = 1;
                    else if (qc != ec)
                    begin
                        same = 0;
                        done = 1;
                    end
                end
            end
            if (same)
            begin
                hit = 1;
                hit_base = base;
            end
        end
        if (!hit)
        begin
            chs_expect_q.push_back(MISS_BEAT);
            return;
        end
        for (x = SLOT_BASE; x < ENT_STRIDE; x++)
        begin
            if (dir_img[hit_base + x] != 8'd0)
            begin
                chs_expect_q.push_back(chs_of(9'(hit_base), x - SLOT_BASE,
                                              int'(dir_img[hit_base + x])));
                n++;
            end
        end
        if (n == 0)
        begin
            b = MISS_BEAT;
            b.found = 1'b1;
            b.entry_offset = 9'(hit_base);
            chs_expect_q.push_back(b);
        end
        else
            chs_expect_q[chs_expect_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string fname, input logic [8:0] want,
                                        input logic [8:0] got, inout bit bad);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            bad = 1;
        end
    endfunction

    always @(posedge clk)
    begin
        chs_beat_t want;
        bit bad;
        if (rst_n && strobe)
        begin
            beats_seen++;
            if (found)
                hit_beats++;
            if (chs_expect_q.size() == 0)
            begin
                $display("%0t: beat with nothing expected, expected none got found %0h off %0h",
                         $time, found, entry_offset);
                errors++;
            end
            else
            begin
                want = chs_expect_q.pop_front();
                bad = 0;
                check_field("found", 9'(want.found), 9'(found), bad);
                check_field("entry_offset", want.entry_offset, entry_offset, bad);
                check_field("sector_valid", 9'(want.sector_valid), 9'(sector_valid), bad);
                check_field("slot_index", 9'(want.slot_index), 9'(slot_index), bad);
                check_field("sector_number", 9'(want.sector_number), 9'(sector_number), bad);
                check_field("cylinder", 9'(want.cylinder), 9'(cylinder), bad);
                check_field("head_select", 9'(want.head_select), 9'(head_select), bad);
                check_field("track_sector", 9'(want.track_sector), 9'(track_sector), bad);
                check_field("last", 9'(want.last), 9'(last), bad);
                if (bad)
                    errors++;
            end
        end
    end

    function automatic int draw_gap();
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        return gap;
    endfunction

    // Hold the beat until busy is low at an edge; predict on acceptance.
    task automatic issue(input logic op, input logic [8:0] addr, input logic [7:0] val,
                         input logic [79:0] q, input bit typed, input chs_beat_t beat);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        byte_address <= addr;
        byte_value   <= val;
        name_head    <= q[63:0];
        name_tail    <= q[79:64];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands++;
        if (op == fdl_pkg::OP_WRITE)
            dir_img[addr] = val;
        else
        begin
            lookups++;
            if (typed)
                chs_expect_q.push_back(beat);
            else
                resolve_name(q);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (chs_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [79:0] junk80();
        return 80'({$urandom(), $urandom(), $urandom()});
    endfunction

    task automatic write_staged();
        int a;
        for (a = 0; a < DIR_SIZE; a++)
            issue(fdl_pkg::OP_WRITE, 9'(a), staged_img[a], junk80(), 0, NO_BEAT);
    endtask

    function automatic void put_name(input int e, input string s);
        int i;
        for (i = 0; i < NAME_LEN; i++)
            staged_img[e*ENT_STRIDE + i] = (i < s.len()) ? s[i] : 8'd0;
    endfunction

    function automatic void stage_directed();
        int a;
        int e;
        int k;
        for (a = 0; a < DIR_SIZE; a++)
            staged_img[a] = 8'd0;
        put_name(0, "ALPHA");
        staged_img[SLOT_BASE + 0] = 8'd1;
        staged_img[SLOT_BASE + 1] = 8'd35;
        staged_img[SLOT_BASE + 2] = 8'd36;
        for (k = 0; k < NAME_LEN; k++)
            staged_img[ENT_STRIDE + k] = 8'hFF;
        for (k = 0; k < 21; k++)
            staged_img[ENT_STRIDE + SLOT_BASE + k] = 8'(k * 12 + 7);
        put_name(2, "NOSECTORS");
        put_name(3, "ALPHA");
        staged_img[3*ENT_STRIDE + SLOT_BASE + 3] = 8'd100;
        put_name(4, "DIR\nNAME\nX");
        for (k = 0; k < 21; k++)
            staged_img[4*ENT_STRIDE + SLOT_BASE + k] = 8'(k * 8);
        for (e = 5; e < 15; e++)
        begin
            for (k = 0; k < NAME_LEN; k++)
                staged_img[e*ENT_STRIDE + k] = 8'("a" + e);
            staged_img[e*ENT_STRIDE + NAME_LEN] = 8'(e);
            staged_img[e*ENT_STRIDE + SLOT_BASE + e - 5] = 8'(e * 17);
        end
        put_name(15, "LASTENTRY1");
        staged_img[DIR_SIZE - 1] = 8'd255;
    endfunction

    task automatic random_item();
        int r;
        int e;
        int y;
        int z;
        logic [8:0]  addr;
        logic [7:0]  val;
        logic [79:0] q;
        r = $urandom_range(99);
        e = $urandom_range(DIR_SIZE / ENT_STRIDE - 1);
        if (r < 30)
        begin
            case ($urandom_range(4))
                0, 1: addr = 9'(e*ENT_STRIDE + SLOT_BASE + $urandom_range(20));
                2:    addr = 9'(e*ENT_STRIDE + $urandom_range(NAME_LEN - 1));
                default: addr = 9'($urandom());
            endcase
            val = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom());
            issue(fdl_pkg::OP_WRITE, addr, val, junk80(), 0, NO_BEAT);
        end
        else
        begin
            q = junk80();
            if (r < 85)
            begin
                z = -1;
                for (y = NAME_LEN - 1; y >= 0; y--)
                begin
                    q[8*y +: 8] = dir_img[e*ENT_STRIDE + y];
                    if (dir_img[e*ENT_STRIDE + y] == 8'd0)
                        z = y;
                end
                if (z >= 0 && $urandom_range(2) == 0)
                begin
                    q[8*z +: 8] = fdl_pkg::QUERY_END;
                    for (y = z + 1; y < NAME_LEN; y++)
                        q[8*y +: 8] = 8'($urandom());
                end
                else if ($urandom_range(4) == 0)
                    q[$urandom_range(79)] = ~q[$urandom_range(79)];
            end
            issue(fdl_pkg::OP_LOOKUP, 9'($urandom()), 8'($urandom()), q, 0, NO_BEAT);
        end
    endtask

    initial
    begin
        int i;
        int ph;
        int phase_pct [3];
        phase_pct = '{0, 73, 12};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("ALPHA\n"), 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("ALPHA"), 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, {80{1'b1}}, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("NOSECTORS\n"), 1,
                         '{1'b1, 9'd64, 1'b0, 5'd0, 8'd0, 3'd0, 1'b0, 5'd0, 1'b1}});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, 80'd0, 1, MISS_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("LASTENTRY1"), 1,
                         '{1'b1, 9'd480, 1'b1, 5'd20, 8'd255, 3'd7, 1'b0, 5'd4, 1'b1}});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("DIR\nNAME\nX"), 0,
                         NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("\n"), 1, MISS_BEAT});
        plan.push_back('{fdl_pkg::OP_WRITE, 9'd11, 8'd0, 80'd0, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("ALPHA"), 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_WRITE, 9'd511, 8'd200, 80'd0, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("LASTENTRY1"), 0,
                         NO_BEAT});
        plan.push_back('{fdl_pkg::OP_WRITE, 9'd0, 8'd0, 80'd0, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("\n"), 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("ALPHA"), 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_WRITE, 9'd0, 8'h41, 80'd0, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_WRITE, 9'd511, 8'hFF, {80{1'b1}}, 0, NO_BEAT});
        plan.push_back('{fdl_pkg::OP_LOOKUP, 9'd0, 8'd0, pack_name("LASTENTRY1"), 1,
                         '{1'b1, 9'd480, 1'b1, 5'd20, 8'd255, 3'd7, 1'b0, 5'd4, 1'b1}});

        stage_directed();
        write_staged();
        foreach (plan[i])
            issue(plan[i].op, plan[i].addr, plan[i].val, plan[i].qname,
                  plan[i].typed, plan[i].beat);

        for (ph = 0; ph < 3; ph++)
        begin
            drain();
            idle_pct = phase_pct[ph];
            for (i = 0; i < 140; i++)
            begin
                if ($urandom_range(49) == 0)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (250) @(posedge clk);
        $display("ran %0d commands, %0d of them name lookups, over three idle settings",
                 commands, lookups);
        $display("checked %0d result beats, %0d from matched entries", beats_seen, hit_beats);
        if (errors == 0 && chs_expect_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* flat_directory_lookup_chs_top.f */
src/fdl_pkg.sv
src/fdl_ram.sv
src/fdl_seq.sv
src/fdl_chs.sv
src/flat_directory_lookup_chs_top.sv
tb/tb_top.sv
